// File: design/ansi_sgr_tag_filter_unit_assert.svh
// Assertion macros used by the RTL parser.
// ASGR_ASSERT checks only out of reset; ASGR_ASSERT_ALWAYS checks at every edge.
`ifndef ANSI_SGR_TAG_FILTER_UNIT_ASSERT_SVH
`define ANSI_SGR_TAG_FILTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ASGR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define ASGR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");
`else
`define ASGR_ASSERT(lbl, prop)
`define ASGR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: design/asgr_pkg.sv
`default_nettype none

package asgr_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned WeightW = 2;
    localparam int unsigned ColorW  = 4;
    localparam int unsigned TdataW  = 24;

    localparam logic [CharW-1:0] ByteEsc    = 8'h1B;
    localparam logic [CharW-1:0] ByteOpen   = 8'h5B;
    localparam logic [CharW-1:0] ByteClose  = 8'h5D;
    localparam logic [CharW-1:0] ByteSemi   = 8'h3B;
    localparam logic [CharW-1:0] ByteFinal  = 8'h6D;
    localparam logic [CharW-1:0] ByteDigLo  = 8'd48;
    localparam logic [CharW-1:0] ByteDigHi  = 8'd57;

    localparam logic [CharW-1:0] SgrReset      = 8'd0;
    localparam logic [CharW-1:0] SgrBold       = 8'd1;
    localparam logic [CharW-1:0] SgrThin       = 8'd2;
    localparam logic [CharW-1:0] SgrItalic     = 8'd3;
    localparam logic [CharW-1:0] SgrUnderline  = 8'd4;
    localparam logic [CharW-1:0] SgrNormal     = 8'd22;
    localparam logic [CharW-1:0] SgrItalicOff  = 8'd23;
    localparam logic [CharW-1:0] SgrUnderOff   = 8'd24;
    localparam logic [CharW-1:0] SgrForeLo     = 8'd30;
    localparam logic [CharW-1:0] SgrForeHi     = 8'd37;
    localparam logic [CharW-1:0] SgrBackLo     = 8'd40;
    localparam logic [CharW-1:0] SgrBackHi     = 8'd47;
    localparam logic [CharW-1:0] SgrForeBias   = 8'd29;
    localparam logic [CharW-1:0] SgrBackBias   = 8'd39;

    localparam logic [WeightW-1:0] WeightNormal = 2'd0;
    localparam logic [WeightW-1:0] WeightBold   = 2'd1;
    localparam logic [WeightW-1:0] WeightThin   = 2'd2;

    localparam logic [ColorW-1:0] ColorDefault = 4'd0;
    localparam logic [ColorW-1:0] ColorMax     = 4'd8;

    // packed lowest field last so out_char lands in bit 0
    typedef struct packed {
        logic [ColorW-1:0]  back_color;
        logic [ColorW-1:0]  fore_color;
        logic               underline;
        logic               italic;
        logic [WeightW-1:0] weight;
        logic [CharW-1:0]   out_char;
    } t_result;

    localparam int unsigned ResultW = $bits(t_result);

endpackage

`default_nettype wire

// File: design/asgr_in_reg.sv
`default_nettype none

module asgr_in_reg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [asgr_pkg::CharW-1:0] i_byte,
    input  wire logic                      i_advance,
    output logic                           o_valid,
    output logic [asgr_pkg::CharW-1:0]     o_byte
);
    import asgr_pkg::*;

    logic             r_valid;
    logic [CharW-1:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

// File: design/asgr_parser.sv
`default_nettype none

module asgr_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [asgr_pkg::CharW-1:0] i_byte,
    input  wire logic                       i_keep_tags,
    output logic                            o_emit,
    output asgr_pkg::t_result               o_result
);
    import asgr_pkg::*;

    `include "ansi_sgr_tag_filter_unit_assert.svh"

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TAG  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_SGR  = 2'd3
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [CharW-1:0]   r_accum, n_accum;
    logic [WeightW-1:0] r_weight, n_weight;
    logic               r_italic, n_italic;
    logic               r_under, n_under;
    logic [ColorW-1:0]  r_fore, n_fore;
    logic [ColorW-1:0]  r_back, n_back;

    logic               apply;
    logic               is_digit;
    logic [11:0]        acc_sum;
    logic [CharW-1:0]   fore_code;
    logic [CharW-1:0]   back_code;

    assign is_digit  = (i_byte >= ByteDigLo) && (i_byte <= ByteDigHi);
    assign acc_sum   = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1)
                     + {8'd0, i_byte[3:0]};
    assign fore_code = r_accum - SgrForeBias;
    assign back_code = r_accum - SgrBackBias;

    assign o_result.out_char   = i_byte;
    assign o_result.weight     = r_weight;
    assign o_result.italic     = r_italic;
    assign o_result.underline  = r_under;
    assign o_result.fore_color = r_fore;
    assign o_result.back_color = r_back;

    always_comb begin
        n_mode = r_mode;
        n_accum = r_accum;
        o_emit = 1'b0;
        apply = 1'b0;
        unique case (r_mode)
            MODE_TAG: begin
                if (i_byte == ByteClose) begin
                    n_mode = MODE_IDLE;
                end
                o_emit = i_keep_tags;
            end
            MODE_ESC: begin
                if (i_byte == ByteOpen) begin
                    n_mode  = MODE_SGR;
                    n_accum = '0;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_SGR: begin
                priority if (is_digit) begin
                    n_accum = (acc_sum > 12'd255) ? 8'd255 : acc_sum[7:0];
                end else if (i_byte == ByteSemi) begin
                    apply   = 1'b1;
                    n_accum = '0;
                end else if (i_byte == ByteFinal) begin
                    apply   = 1'b1;
                    n_accum = '0;
                    n_mode  = MODE_IDLE;
                end else begin
                    n_accum = '0;
                    n_mode  = MODE_IDLE;
                end
            end
            MODE_IDLE: begin
                priority if (i_byte == ByteOpen) begin
                    n_mode = MODE_TAG;
                    o_emit = i_keep_tags;
                end else if (i_byte == ByteEsc) begin
                    n_mode = MODE_ESC;
                end else begin
                    o_emit = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        n_weight = r_weight;
        n_italic = r_italic;
        n_under  = r_under;
        n_fore   = r_fore;
        n_back   = r_back;
        if (apply) begin
            priority if (r_accum == SgrReset) begin
                n_weight = WeightNormal;
                n_italic = 1'b0;
                n_under  = 1'b0;
                n_fore   = ColorDefault;
                n_back   = ColorDefault;
            end else if (r_accum == SgrBold) begin
                n_weight = WeightBold;
            end else if (r_accum == SgrThin) begin
                n_weight = WeightThin;
            end else if (r_accum == SgrItalic) begin
                n_italic = 1'b1;
            end else if (r_accum == SgrUnderline) begin
                n_under = 1'b1;
            end else if (r_accum == SgrNormal) begin
                n_weight = WeightNormal;
            end else if (r_accum == SgrItalicOff) begin
                n_italic = 1'b0;
            end else if (r_accum == SgrUnderOff) begin
                n_under = 1'b0;
            end else if (r_accum >= SgrForeLo && r_accum <= SgrForeHi) begin
                n_fore = fore_code[ColorW-1:0];
            end else if (r_accum >= SgrBackLo && r_accum <= SgrBackHi) begin
                n_back = back_code[ColorW-1:0];
            end else begin
                n_weight = r_weight;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_accum  <= '0;
            r_weight <= WeightNormal;
            r_italic <= 1'b0;
            r_under  <= 1'b0;
            r_fore   <= ColorDefault;
            r_back   <= ColorDefault;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_accum  <= n_accum;
            r_weight <= n_weight;
            r_italic <= n_italic;
            r_under  <= n_under;
            r_fore   <= n_fore;
            r_back   <= n_back;
        end
    end

    `ASGR_ASSERT(a_weight_range, r_weight != 2'd3)
    `ASGR_ASSERT(a_color_range, (r_fore <= ColorMax) && (r_back <= ColorMax))
    `ASGR_ASSERT(a_accum_clear_open,
        (i_step && r_mode == MODE_ESC && i_byte == ByteOpen) |=> (r_accum == '0))
    `ASGR_ASSERT(a_emit_only_idle_tag,
        o_emit |-> (r_mode == MODE_IDLE || r_mode == MODE_TAG))
    `ASGR_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_mode == MODE_IDLE && r_accum == '0))

endmodule

`default_nettype wire

// File: design/asgr_out_reg.sv
`default_nettype none

module asgr_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire asgr_pkg::t_result i_result,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output asgr_pkg::t_result      o_result
);
    import asgr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: design/ansi_sgr_tag_filter_unit.sv
// Byte-stream filter that strips ANSI SGR escape sequences (ESC '[' params 'm')
// and tags each passed byte with the current text attributes. Bracketed tags
// are passed or dropped per the keep_tags register (cfg port, reset 1). One
// byte is taken every clock cycle unless stalled; a byte that yields a result
// is offered on the master side after the input register and then the result
// register. Bytes consumed by a sequence produce no output
// transaction. The master side stalls the slave side only while the result
// register is full and not taken. Write keep_tags only while the block is idle.
`default_nettype none

module ansi_sgr_tag_filter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] out_char, [9:8] weight,
                                             // [10] italic, [11] underline,
                                             // [15:12] fore_color, [19:16] back_color
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data      // keep_tags
);
    import asgr_pkg::*;

    logic             r_keep_tags;
    logic             in_valid;
    logic [CharW-1:0] in_byte;
    logic             advance;
    logic             emit;
    logic             out_free;
    t_result          result;
    t_result          out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_tags <= 1'b1;
        end else if (i_cfg_valid) begin
            r_keep_tags <= i_cfg_data;
        end
    end

    assign advance = in_valid && (!emit || out_free);

    asgr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    asgr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (in_byte),
        .i_keep_tags (r_keep_tags),
        .o_emit      (emit),
        .o_result    (result)
    );

    asgr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {(TdataW - ResultW)'(0), out_result};

endmodule

`default_nettype wire

// File: tb/sv/asgr_attr_checker.sv
module asgr_attr_checker
    import asgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef enum logic [1:0] {ModeIdle, ModeTag, ModeEsc, ModeSgr} t_parse_mode;

    t_parse_mode parse_mode;
    logic        keep_tags;
    logic [7:0]  param_accum;
    t_result     cur_attr;
    t_result     styled_chars_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic push_styled_char(input logic [7:0] c);
        t_result r;
        r          = cur_attr;
        r.out_char = c;
        styled_chars_q.push_back(r);
    endtask

    task automatic apply_sgr_code(input logic [7:0] code);
        if (code == SgrReset) begin
            cur_attr.weight     = WeightNormal;
            cur_attr.italic     = 1'b0;
            cur_attr.underline  = 1'b0;
            cur_attr.fore_color = ColorDefault;
            cur_attr.back_color = ColorDefault;
        end else if (code == SgrBold) begin
            cur_attr.weight = WeightBold;
        end else if (code == SgrThin) begin
            cur_attr.weight = WeightThin;
        end else if (code == SgrItalic) begin
            cur_attr.italic = 1'b1;
        end else if (code == SgrUnderline) begin
            cur_attr.underline = 1'b1;
        end else if (code == SgrNormal) begin
            cur_attr.weight = WeightNormal;
        end else if (code == SgrItalicOff) begin
            cur_attr.italic = 1'b0;
        end else if (code == SgrUnderOff) begin
            cur_attr.underline = 1'b0;
        end else if (code >= SgrForeLo && code <= SgrForeHi) begin
            cur_attr.fore_color = ColorW'(code - SgrForeBias);
        end else if (code >= SgrBackLo && code <= SgrBackHi) begin
            cur_attr.back_color = ColorW'(code - SgrBackBias);
        end
    endtask

    task automatic track_sgr_byte(input logic [7:0] c);
        logic [11:0] acc_next;
        acc_next = param_accum * 12'd10 + 12'(c - ByteDigLo);
        case (parse_mode)
            ModeTag: begin
                if (c == ByteClose) parse_mode = ModeIdle;
                if (keep_tags) push_styled_char(c);
            end
            ModeEsc: begin
                if (c == ByteOpen) begin
                    parse_mode  = ModeSgr;
                    param_accum = '0;
                end else begin
                    parse_mode = ModeIdle;
                end
            end
            ModeSgr: begin
                if (c >= ByteDigLo && c <= ByteDigHi) begin
                    // saturate at 255
                    param_accum = (acc_next[11:8] != '0) ? '1 : acc_next[7:0];
                end else if (c == ByteSemi) begin
                    apply_sgr_code(param_accum);
                    param_accum = '0;
                end else if (c == ByteFinal) begin
                    apply_sgr_code(param_accum);
                    param_accum = '0;
                    parse_mode  = ModeIdle;
                end else begin
                    param_accum = '0;
                    parse_mode  = ModeIdle;
                end
            end
            default: begin
                if (c == ByteOpen) begin
                    parse_mode = ModeTag;
                    if (keep_tags) push_styled_char(c);
                end else if (c == ByteEsc) begin
                    parse_mode = ModeEsc;
                end else begin
                    push_styled_char(c);
                end
            end
        endcase
    endtask

    task automatic check_styled_char(input t_result got);
        t_result want;
        if (styled_chars_q.size() == 0) begin
            if (o_fail_count < 10)
                $display("unexpected result: char %h wt %0d it %0d ul %0d fg %0d bg %0d",
                         got.out_char, got.weight, got.italic, got.underline,
                         got.fore_color, got.back_color);
            o_fail_count++;
        end else begin
            want = styled_chars_q.pop_front();
            if (got.out_char !== want.out_char || got.weight !== want.weight ||
                got.italic !== want.italic || got.underline !== want.underline ||
                got.fore_color !== want.fore_color || got.back_color !== want.back_color) begin
                if (o_fail_count < 10)
                    $display({"mismatch: exp char %h wt %0d it %0d ul %0d fg %0d bg %0d,",
                              " got char %h wt %0d it %0d ul %0d fg %0d bg %0d"},
                             want.out_char, want.weight, want.italic, want.underline,
                             want.fore_color, want.back_color,
                             got.out_char, got.weight, got.italic, got.underline,
                             got.fore_color, got.back_color);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_mode  = ModeIdle;
            keep_tags   = 1'b1;
            param_accum = '0;
            cur_attr    = '0;
            styled_chars_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) keep_tags = i_cfg_data;
            if (i_m_tvalid && i_m_tready) check_styled_char(t_result'(i_m_tdata[ResultW-1:0]));
            if (i_s_tvalid && i_s_tready) track_sgr_byte(i_s_tdata);
        end
        o_pending = styled_chars_q.size();
    end

endmodule

// File: tb/sv/tb_ansi_sgr_tag_filter_unit.sv
module tb_ansi_sgr_tag_filter_unit;
    import asgr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] out_char, [9:8] weight, [10] italic,
                                 // [11] underline, [15:12] fore_color, [19:16] back_color
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    int          fail_count;
    int          pending;
    bit          steady;
    bit          hold_req;
    logic [7:0]  stim_q[$];

    always #2 i_clk = ~i_clk;

    ansi_sgr_tag_filter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    asgr_attr_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random stalls, a long hold-off on request
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 27);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    // write keep_tags once the block has drained
    task automatic set_keep_tags(input logic v);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_sgr_code();
        logic [7:0] code;
        case ($urandom_range(9))
            0:       code = SgrReset;
            1:       code = SgrBold;
            2:       code = SgrThin;
            3:       code = SgrItalic;
            4:       code = SgrUnderline;
            5:       code = SgrNormal;
            6:       code = SgrItalicOff;
            7:       code = SgrUnderOff;
            8:       code = SgrForeLo + 8'($urandom_range(7));
            default: code = SgrBackLo + 8'($urandom_range(7));
        endcase
        return code;
    endfunction

    task automatic push_decimal(input int v);
        logic [7:0] digits[$];
        do begin
            digits.push_front(ByteDigLo + 8'(v % 10));
            v = v / 10;
        end while (v > 0);
        foreach (digits[k]) stim_q.push_back(digits[k]);
    endtask

    task automatic add_random_chunk();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 35) begin
            stim_q.push_back(ByteEsc);
            stim_q.push_back(ByteOpen);
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                if (k > 0) stim_q.push_back(ByteSemi);
                pick = $urandom_range(99);
                if (pick < 75) push_decimal(pick_sgr_code());
                else if (pick < 90) push_decimal($urandom_range(999));
            end
            b = 8'($urandom_range(255));
            if ($urandom_range(99) < 85 || (b >= ByteDigLo && b <= ByteDigHi) || b == ByteSemi)
                b = ByteFinal;
            stim_q.push_back(b);
        end else if (pick < 60) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                b = 8'($urandom_range(32, 126));
                if (b == ByteOpen) b = ByteClose;
                stim_q.push_back(b);
            end
        end else if (pick < 80) begin
            stim_q.push_back(ByteOpen);
            n = $urandom_range(0, 5);
            repeat (n) begin
                b = 8'($urandom_range(255));
                if (b == ByteClose) b = ByteEsc;
                stim_q.push_back(b);
            end
            stim_q.push_back(ByteClose);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) stim_q.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: attributes, saturation, empty param, aborted sequences, tags
        send_byte(ByteEsc); send_str("[1;42mA");
        send_byte(ByteEsc); send_str("[300mB");
        send_byte(ByteEsc); send_str("[;mC");
        send_byte(ByteEsc); send_str("X]");
        send_byte(ByteEsc); send_str("[3[D");
        send_byte(ByteEsc); send_str("[4"); send_byte(ByteEsc); send_str("F");
        send_str("["); send_byte(ByteEsc); send_str("]");
        // keep_tags flipped in the middle of a tag
        send_str("[a");
        set_keep_tags(1'b0);
        send_str("b]E");

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       set_keep_tags(1'b1);
                1, 2:    set_keep_tags(1'b0);
                3:       set_keep_tags(1'b1);
                default: set_keep_tags(1'($urandom_range(1)));
            endcase
            steady = (phase == 2);
            if (phase == 3) hold_req = 1'b1;
            stim_q.delete();
            while (stim_q.size() < 100) add_random_chunk();
            foreach (stim_q[k]) send_byte(stim_q[k]);
        end
        steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
